// File: src/lobm_pkg.sv
// lobm_pkg: shared constants, codes and control types of the order book matcher
// no dependencies; used by the controller, datapath and top level
package lobm_pkg;

  localparam int BOOK_DEPTH = 32;
  localparam int IDX_W      = $clog2(BOOK_DEPTH);
  localparam int MAX_FILLS  = 32;
  localparam int FILL_W     = $clog2(MAX_FILLS + 1);

  localparam logic [1:0] KIND_LIMIT  = 2'd0;
  localparam logic [1:0] KIND_MARKET = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [2:0] RK_TRADE     = 3'd0;
  localparam logic [2:0] RK_RESTED    = 3'd1;
  localparam logic [2:0] RK_DONE      = 3'd2;
  localparam logic [2:0] RK_MKT_DROP  = 3'd3;
  localparam logic [2:0] RK_CANCELLED = 3'd4;
  localparam logic [2:0] RK_NOT_FOUND = 3'd5;
  localparam logic [2:0] RK_FULL      = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TRADE,
    ST_CHECK,
    ST_REST,
    ST_STATUS
  } lobm_state_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_step;
    logic       emit_trade;
    logic       emit_status;
    logic [2:0] status_kind;
    logic       cancel_commit;
    logic       rest_commit;
  } lobm_cmd_t;

  typedef struct packed {
    logic       scan_last;
    logic       found;
    logic       qty_zero;
    logic       fills_max;
    logic       free_avail;
    logic       out_free;
    logic [1:0] kind;
  } lobm_stat_t;

endpackage

// File: src/lobm_order_if.sv
// lobm_order_if: request channel carrying one order
// depends on nothing
interface lobm_order_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        side;
  logic [31:0] ord_id;
  logic [31:0] limit_price;
  logic [31:0] order_quantity;
  logic [63:0] arrival_time;

  modport source (output valid, kind, side, ord_id, limit_price, order_quantity,
                  arrival_time, input ready);
  modport sink (input valid, kind, side, ord_id, limit_price, order_quantity,
                arrival_time, output ready);
endinterface

// File: src/lobm_result_if.sv
// lobm_result_if: result channel carrying one trade or status result
// depends on nothing
interface lobm_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [31:0] maker_order_id;
  logic [31:0] taker_order_id;
  logic [31:0] exec_price;
  logic [31:0] exec_quantity;
  logic [63:0] maker_time;
  logic [63:0] taker_time;
  logic        last;

  modport source (output valid, result_kind, maker_order_id, taker_order_id, exec_price,
                  exec_quantity, maker_time, taker_time, last, input ready);
  modport sink (input valid, result_kind, maker_order_id, taker_order_id, exec_price,
                exec_quantity, maker_time, taker_time, last, output ready);
endinterface

// File: src/lobm_ctrl.sv
// lobm_ctrl: sequencing state machine of the matcher
// depends on lobm_pkg; drives lobm_datapath through lobm_cmd_t
module lobm_ctrl
  import lobm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lobm_stat_t stat,
  output lobm_cmd_t  cmd
);

  lobm_state_t state, state_next;
  logic [2:0]  st_kind, st_kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      st_kind <= RK_DONE;
    end else begin
      state   <= state_next;
      st_kind <= st_kind_next;
    end
  end

  always_comb begin
    state_next   = state;
    st_kind_next = st_kind;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.kind == KIND_NONE) begin
          state_next   = ST_STATUS;
          st_kind_next = RK_DONE;
        end else if (stat.kind != KIND_CANCEL && stat.qty_zero) begin
          state_next   = ST_STATUS;
          st_kind_next = RK_DONE;
        end else if (stat.scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.kind == KIND_CANCEL) begin
          state_next   = ST_STATUS;
          st_kind_next = stat.found ? RK_CANCELLED : RK_NOT_FOUND;
        end else if (stat.found) begin
          state_next = ST_TRADE;
        end else if (stat.kind == KIND_MARKET) begin
          state_next   = ST_STATUS;
          st_kind_next = RK_MKT_DROP;
        end else begin
          state_next = ST_REST;
        end
      end
      ST_TRADE: begin
        if (stat.out_free) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.qty_zero) begin
          state_next   = ST_STATUS;
          st_kind_next = RK_DONE;
        end else if (stat.fills_max) begin
          if (stat.kind == KIND_MARKET) begin
            state_next   = ST_STATUS;
            st_kind_next = RK_MKT_DROP;
          end else begin
            state_next = ST_REST;
          end
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_REST: begin
        state_next   = ST_STATUS;
        st_kind_next = stat.free_avail ? RK_RESTED : RK_FULL;
      end
      ST_STATUS: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.status_kind = st_kind;
    in_ready        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        cmd.scan_start = in_valid;
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DECIDE: cmd.cancel_commit = (stat.kind == KIND_CANCEL) && stat.found;
      ST_TRADE:  cmd.emit_trade = stat.out_free;
      ST_CHECK:  cmd.scan_start = 1'b1;
      ST_REST:   cmd.rest_commit = stat.free_avail;
      ST_STATUS: cmd.emit_status = stat.out_free;
      default:   cmd = '0;
    endcase
  end

  a_trade_follows_find: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRADE) |-> (($past(state) == ST_DECIDE) || ($past(state) == ST_TRADE)))
    else $error("trade state entered without a found maker");

  a_one_status: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_status |=> (state == ST_IDLE))
    else $error("status emitted without ending the run");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.emit_trade || cmd.emit_status))
    else $error("new order taken while a result is being produced");

endmodule

// File: src/lobm_datapath.sv
// lobm_datapath: slot storage, best-maker scan, fill arithmetic and result register
// depends on lobm_pkg; commanded by lobm_ctrl
module lobm_datapath
  import lobm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lobm_cmd_t   cmd,
  output lobm_stat_t  stat,
  input  logic [1:0]  kind,
  input  logic        side,
  input  logic [31:0] ord_id,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_quantity,
  input  logic [63:0] arrival_time,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  result_kind,
  output logic [31:0] maker_order_id,
  output logic [31:0] taker_order_id,
  output logic [31:0] exec_price,
  output logic [31:0] exec_quantity,
  output logic [63:0] maker_time,
  output logic [63:0] taker_time,
  output logic        last
);

  logic [BOOK_DEPTH-1:0] slot_valid;
  logic                  slot_side     [BOOK_DEPTH];
  logic [31:0]           slot_order_id [BOOK_DEPTH];
  logic [31:0]           slot_price    [BOOK_DEPTH];
  logic [31:0]           slot_quantity [BOOK_DEPTH];
  logic [63:0]           slot_time     [BOOK_DEPTH];
  logic [31:0]           slot_arrival  [BOOK_DEPTH];
  logic [31:0]           arrival_counter;

  logic [1:0]  o_kind;
  logic        o_side;
  logic [31:0] o_id, o_limit, o_qty;
  logic [63:0] o_time;

  logic [IDX_W-1:0]  idx, best_idx, free_idx;
  logic              found, free_avail;
  logic [31:0]       best_price, best_age, best_qty, best_id;
  logic [63:0]       best_time;
  logic [FILL_W-1:0] fills;

  logic        c_valid, c_side;
  logic [31:0] c_price, c_age, c_id, fill_qty;
  logic        qualify, better, take;

  assign c_valid = slot_valid[idx];
  assign c_side  = slot_side[idx];
  assign c_price = slot_price[idx];
  assign c_id    = slot_order_id[idx];
  assign c_age   = arrival_counter - slot_arrival[idx];

  always_comb begin
    if (o_kind == KIND_CANCEL) begin
      qualify = c_valid && (c_id == o_id);
      better  = !found || (c_age < best_age);
    end else begin
      qualify = c_valid && (c_side != o_side) &&
                ((o_kind == KIND_MARKET) ||
                 (o_side ? (c_price >= o_limit) : (c_price <= o_limit)));
      if (!found)                    better = 1'b1;
      else if (c_price != best_price) better = o_side ? (c_price > best_price)
                                                      : (c_price < best_price);
      else                           better = c_age > best_age;
    end
    take = cmd.scan_step && qualify && better;
  end

  // lowest-numbered free slot
  always_comb begin
    free_idx   = '0;
    free_avail = 1'b0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx   = IDX_W'(i);
        free_avail = 1'b1;
      end
    end
  end

  assign fill_qty = (o_qty < best_qty) ? o_qty : best_qty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      o_kind <= kind;
      o_side <= side;
      o_id   <= ord_id;
      o_limit <= limit_price;
      o_qty  <= order_quantity;
      o_time <= arrival_time;
    end else if (cmd.emit_trade) begin
      o_qty <= o_qty - fill_qty;
    end
    if (cmd.scan_start) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
      if (take) begin
        found      <= 1'b1;
        best_idx   <= idx;
        best_price <= c_price;
        best_age   <= c_age;
        best_qty   <= slot_quantity[idx];
        best_id    <= c_id;
        best_time  <= slot_time[idx];
      end
    end
    if (cmd.load)            fills <= '0;
    else if (cmd.emit_trade) fills <= fills + 1'b1;
    if (cmd.emit_trade) slot_quantity[best_idx] <= best_qty - fill_qty;
    if (cmd.rest_commit) begin
      slot_side[free_idx]     <= o_side;
      slot_order_id[free_idx] <= o_id;
      slot_price[free_idx]    <= o_limit;
      slot_quantity[free_idx] <= o_qty;
      slot_time[free_idx]     <= o_time;
      slot_arrival[free_idx]  <= arrival_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      arrival_counter <= '0;
    end else begin
      if (cmd.emit_trade && (best_qty == fill_qty)) slot_valid[best_idx] <= 1'b0;
      if (cmd.cancel_commit) slot_valid[best_idx] <= 1'b0;
      if (cmd.rest_commit) begin
        slot_valid[free_idx] <= 1'b1;
        arrival_counter      <= arrival_counter + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (cmd.emit_trade || cmd.emit_status) res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_trade) begin
      result_kind    <= RK_TRADE;
      maker_order_id <= best_id;
      exec_price     <= best_price;
      exec_quantity  <= fill_qty;
      maker_time     <= best_time;
      last           <= 1'b0;
    end else if (cmd.emit_status) begin
      result_kind    <= cmd.status_kind;
      maker_order_id <= '0;
      exec_price     <= '0;
      exec_quantity  <= '0;
      maker_time     <= '0;
      last           <= 1'b1;
    end
    if (cmd.emit_trade || cmd.emit_status) begin
      taker_order_id <= o_id;
      taker_time     <= o_time;
    end
  end

  always_comb begin
    stat.scan_last  = (idx == IDX_W'(BOOK_DEPTH - 1));
    stat.found      = found;
    stat.qty_zero   = (o_qty == '0);
    stat.fills_max  = (fills == FILL_W'(MAX_FILLS));
    stat.free_avail = free_avail;
    stat.out_free   = !res_valid || res_ready;
    stat.kind       = o_kind;
  end

  a_book_grows_by_one: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) <= $past($countones(slot_valid)) + 1)
    else $error("more than one order rested in a cycle");

  a_trade_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_trade |-> (fill_qty != '0))
    else $error("trade with zero quantity");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_trade |-> (fills < FILL_W'(MAX_FILLS)))
    else $error("fill limit exceeded");

endmodule

// File: src/limit_order_book_matcher_top.sv
// limit_order_book_matcher_top: price-time priority order book matcher
// depends on lobm_pkg, lobm_order_if, lobm_result_if, lobm_ctrl, lobm_datapath
//
//   channel  modport  payload                                    per request
//   order    sink     kind side ord_id limit_price qty time      one order
//   result   source   result_kind ids price qty times last       1..33 results
//
// each match scan walks all BOOK_DEPTH slots one per cycle
// a fill passes through scan, decide, trade and check; an unused kind, or a limit
// or market order of zero quantity, ends with a done status after its first scan
// step; a cancel goes scan, decide, status; a limit with no fill goes on to rest
// rst is synchronous; it empties the book and clears the arrival counter
// a stalled result holds in the output register and pauses the sequencer at its next result
module limit_order_book_matcher_top
  import lobm_pkg::*;
(
  input logic           clk,
  input logic           rst,
  lobm_order_if.sink    order,
  lobm_result_if.source result
);

  lobm_cmd_t  cmd;
  lobm_stat_t stat;

  // controller: one order in flight, ready only while idle
  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (order.valid),
    .in_ready (order.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: slots, scan, fill math and the result register
  lobm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (order.kind),
    .side           (order.side),
    .ord_id         (order.ord_id),
    .limit_price    (order.limit_price),
    .order_quantity (order.order_quantity),
    .arrival_time   (order.arrival_time),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .result_kind    (result.result_kind),
    .maker_order_id (result.maker_order_id),
    .taker_order_id (result.taker_order_id),
    .exec_price     (result.exec_price),
    .exec_quantity  (result.exec_quantity),
    .maker_time     (result.maker_time),
    .taker_time     (result.taker_time),
    .last           (result.last)
  );

endmodule
